// ===== rtl/ncpe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the NURBS curve point evaluator.
package ncpe_pkg;

    // Default sizing of the tables
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT  = 1'd1;
    localparam logic [1:0] DEGREE_RESET = 2'd3;
    localparam logic [6:0] COUNT_RESET  = 7'd0;

    // Function codes of an input transaction
    localparam logic [1:0] FUNC_WR_POINT = 2'd0;
    localparam logic [1:0] FUNC_WR_KNOT  = 2'd1;
    localparam logic [1:0] FUNC_EVAL     = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FEW     = 2'd1;
    localparam logic [1:0] STAT_UNNORM  = 2'd2;

    // Fixed-point formats
    localparam int NB_W   = 27;   // basis value, signed Q24 clamped to +-2.0
    localparam int DIFF_W = 33;   // knot difference, signed
    localparam int DEN_W  = 34;   // recurrence denominator, signed
    localparam int WN_W   = 32;   // basis times weight, signed Q20
    localparam int WN_SHIFT = 20;
    localparam logic signed [NB_W-1:0] BASIS_ONE = 27'sd16777216;
    localparam logic signed [NB_W-1:0] BASIS_LIM = 27'sd33554432;

    // Shared divider
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 35;
    localparam int DIV_STEPS = 2;     // quotient bits per cycle

    typedef struct packed {
        logic [1:0]         func;
        logic [6:0]         slot;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [23:0]        point_weight;
        logic [31:0]        knot_value;
        logic [31:0]        param_t;
    } ncpe_in_t;

    typedef struct packed {
        logic signed [31:0] curve_x;
        logic signed [31:0] curve_y;
        logic [1:0]         eval_status;
    } ncpe_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [23:0]        w;
    } ncpe_point_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] dividend;
        logic signed [DIV_DEN_W-1:0] divisor;
    } ncpe_div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quotient;
    } ncpe_div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HI_RD,
        ST_HI_CMP,
        ST_LO_CMP,
        ST_SCAN,
        ST_KLD,
        ST_KWAIT,
        ST_BMUL_A,
        ST_BDIV_A,
        ST_BWAIT_A,
        ST_BDIV_B,
        ST_BWAIT_B,
        ST_WRD,
        ST_WMUL,
        ST_WSHIFT,
        ST_WACC,
        ST_NORM,
        ST_NDIV_X,
        ST_NWAIT_X,
        ST_NDIV_Y,
        ST_NWAIT_Y,
        ST_DONE
    } ncpe_state_t;

    // Saturate to the int32 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Clamp a basis value to [-2.0, +2.0]
    function automatic logic signed [NB_W-1:0] clamp_basis(input logic signed [63:0] v);
        logic signed [NB_W-1:0] res;
        if (v > 64'sd33554432) begin
            res = BASIS_LIM;
        end else if (v < -64'sd33554432) begin
            res = -BASIS_LIM;
        end else begin
            res = v[NB_W-1:0];
        end
        return res;
    endfunction

    // Divide by 2^20, truncating toward zero
    function automatic logic signed [63:0] shr20_trunc(input logic signed [63:0] v);
        logic signed [63:0] res;
        if (v < 0) begin
            res = (v + 64'sd1048575) >>> WN_SHIFT;
        end else begin
            res = v >>> WN_SHIFT;
        end
        return res;
    endfunction

endpackage

// ===== rtl/nurbs_curve_point_eval_unit.sv =====
// NURBS curve point evaluator: control point and knot tables in block memory, one
// sequencer that walks span search, basis recurrence, weighted sum and normalization.
//
// A control point or knot write to a slot beyond its table is dropped. The span search
// of an evaluation scans the knots one per cycle, up to point_count. The shared
// two-bit-per-cycle divider runs two divisions per basis term with a nonzero
// denominator and two for the final normalization when the weight sum is positive.
// The result waits in an output register, and writes are taken while it waits. No
// clearing pass follows reset; table entries read before being written hold arbitrary
// values.
module nurbs_curve_point_eval_unit #(
    parameter int MAX_POINTS = ncpe_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = ncpe_pkg::MAX_DEGREE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ncpe_pkg::ncpe_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ncpe_pkg::ncpe_out_t                m_data,
    input  logic                               cfg_wr_en,
    input  logic [ncpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ncpe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KA  = $clog2(KNOT_DEPTH);
    localparam int PA  = $clog2(MAX_POINTS);
    localparam int IW  = (KA + 1 > 8) ? KA + 1 : 8;
    localparam int DGW = $clog2(MAX_DEGREE + 1);
    localparam int LDW = $clog2(2 * MAX_DEGREE);
    localparam int NB_W = ncpe_pkg::NB_W;
    localparam int DF_W = ncpe_pkg::DIFF_W;
    localparam int DN_W = ncpe_pkg::DEN_W;
    localparam int WN_W = ncpe_pkg::WN_W;
    localparam int NW   = ncpe_pkg::DIV_NUM_W;
    localparam int DVW  = ncpe_pkg::DIV_DEN_W;

    // Tables
    logic [31:0]          knot_mem [KNOT_DEPTH];
    ncpe_pkg::ncpe_point_t pt_mem  [MAX_POINTS];
    logic [31:0]          knot_rdata;
    ncpe_pkg::ncpe_point_t pt_rdata;
    logic [KA-1:0]        knot_raddr;
    logic [PA-1:0]        pt_raddr;

    // Control and configuration
    ncpe_pkg::ncpe_state_t state_reg, state_next;
    logic [1:0]           deg_reg;
    logic [6:0]           cnt_reg;
    logic                 m_valid_reg;
    ncpe_pkg::ncpe_out_t  m_data_reg;
    logic                 kcap_vld_reg;

    // Evaluation datapath
    logic [31:0]           u_reg;
    logic [DGW-1:0]        p_reg;
    logic [IW-1:0]         n_reg;
    logic [IW-1:0]         span_reg;
    logic [IW-1:0]         scan_k_reg;
    logic [LDW-1:0]        ld_reg;
    logic [LDW-1:0]        ktag_reg;
    logic [DGW-1:0]        j_reg;
    logic [DGW-1:0]        r_reg;
    logic [DGW-1:0]        i_reg;
    logic signed [NB_W-1:0] nb_reg    [MAX_DEGREE+1];
    logic signed [DF_W-1:0] left_reg  [MAX_DEGREE+1];
    logic signed [DF_W-1:0] right_reg [MAX_DEGREE+1];
    logic signed [DN_W-1:0] den_reg;
    logic signed [NW-1:0]   prod_reg;
    logic signed [NW-1:0]   a_reg;
    logic signed [NW-1:0]   saved_reg;
    logic signed [51:0]     prodw_reg;
    logic signed [WN_W-1:0] wn_reg;
    logic signed [31:0]     x_reg;
    logic signed [31:0]     y_reg;
    logic signed [63:0]     sx_reg;
    logic signed [63:0]     sy_reg;
    logic signed [31:0]     ws_reg;
    logic signed [31:0]     res_x_reg;
    logic signed [31:0]     res_y_reg;
    logic [1:0]             res_st_reg;

    ncpe_pkg::ncpe_div_req_t div_req;
    ncpe_pkg::ncpe_div_rsp_t div_rsp;

    // Transaction decode and clamped configuration
    logic           acc_in;
    logic [IW-1:0]  slot_w;
    logic [IW-1:0]  cnt_eff;
    logic [DGW-1:0] p_eff;
    logic           too_few;

    assign acc_in = s_valid && s_ready;
    assign slot_w = IW'(s_data.slot);
    assign cnt_eff = (IW'(cnt_reg) > IW'(MAX_POINTS)) ? IW'(MAX_POINTS) : IW'(cnt_reg);
    always_comb begin
        if (deg_reg == 2'd0) begin
            p_eff = DGW'(1);
        end else if (int'(deg_reg) > MAX_DEGREE) begin
            p_eff = DGW'(MAX_DEGREE);
        end else begin
            p_eff = DGW'(deg_reg);
        end
    end
    assign too_few = cnt_eff < (IW'(p_eff) + IW'(1));

    // Sequencer conditions
    logic [IW-1:0]  rk;
    logic           hi_hit, lo_hit, lo_empty, scan_hit, scan_end;
    logic [LDW-1:0] ld_last;
    logic [DGW-1:0] ld_j;
    logic [DGW-1:0] r1_idx, jr_idx;
    logic           r_last, j_last, i_last, den_zero, out_free;

    assign rk       = scan_k_reg - IW'(1);
    assign hi_hit   = u_reg >= knot_rdata;
    assign lo_hit   = u_reg <= knot_rdata;
    assign lo_empty = IW'(p_reg) >= n_reg;
    assign scan_hit = knot_rdata > u_reg;
    assign scan_end = rk >= n_reg;
    assign ld_last  = LDW'({p_reg, 1'b0} - (DGW + 1)'(1));
    assign ld_j     = DGW'(ld_reg >> 1) + DGW'(1);
    assign r1_idx   = r_reg + DGW'(1);
    assign jr_idx   = j_reg - r_reg;
    assign r_last   = r1_idx == j_reg;
    assign j_last   = j_reg == p_reg;
    assign i_last   = i_reg == p_reg;
    assign den_zero = den_reg == '0;
    assign out_free = !m_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ncpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and memory read addresses
    always_comb begin
        logic [IW-1:0] ka;
        state_next = state_reg;
        ka = '0;
        pt_raddr = '0;
        unique case (state_reg)
            ncpe_pkg::ST_IDLE: begin
                if (acc_in && s_data.func == ncpe_pkg::FUNC_EVAL) begin
                    state_next = too_few ? ncpe_pkg::ST_DONE : ncpe_pkg::ST_HI_RD;
                end
            end
            ncpe_pkg::ST_HI_RD: begin
                ka = n_reg + IW'(1);
                state_next = ncpe_pkg::ST_HI_CMP;
            end
            ncpe_pkg::ST_HI_CMP: begin
                ka = IW'(p_reg);
                state_next = hi_hit ? ncpe_pkg::ST_KLD : ncpe_pkg::ST_LO_CMP;
            end
            ncpe_pkg::ST_LO_CMP: begin
                ka = IW'(p_reg) + IW'(1);
                state_next = (lo_hit || lo_empty) ? ncpe_pkg::ST_KLD : ncpe_pkg::ST_SCAN;
            end
            ncpe_pkg::ST_SCAN: begin
                ka = scan_k_reg;
                if (scan_hit || scan_end) begin
                    state_next = ncpe_pkg::ST_KLD;
                end
            end
            ncpe_pkg::ST_KLD: begin
                // left knots below the span, right knots above it
                ka = ld_reg[0] ? span_reg + IW'(ld_j) : span_reg + IW'(1) - IW'(ld_j);
                if (ld_reg == ld_last) begin
                    state_next = ncpe_pkg::ST_KWAIT;
                end
            end
            ncpe_pkg::ST_KWAIT:  state_next = ncpe_pkg::ST_BMUL_A;
            ncpe_pkg::ST_BMUL_A: state_next = ncpe_pkg::ST_BDIV_A;
            ncpe_pkg::ST_BDIV_A: begin
                if (!den_zero) begin
                    state_next = ncpe_pkg::ST_BWAIT_A;
                end else if (r_last && j_last) begin
                    state_next = ncpe_pkg::ST_WRD;
                end else begin
                    state_next = ncpe_pkg::ST_BMUL_A;
                end
            end
            ncpe_pkg::ST_BWAIT_A: begin
                if (div_rsp.done) begin
                    state_next = ncpe_pkg::ST_BDIV_B;
                end
            end
            ncpe_pkg::ST_BDIV_B: state_next = ncpe_pkg::ST_BWAIT_B;
            ncpe_pkg::ST_BWAIT_B: begin
                if (div_rsp.done) begin
                    state_next = (r_last && j_last) ? ncpe_pkg::ST_WRD : ncpe_pkg::ST_BMUL_A;
                end
            end
            ncpe_pkg::ST_WRD: begin
                pt_raddr = PA'(span_reg - IW'(p_reg) + IW'(i_reg));
                state_next = ncpe_pkg::ST_WMUL;
            end
            ncpe_pkg::ST_WMUL:   state_next = ncpe_pkg::ST_WSHIFT;
            ncpe_pkg::ST_WSHIFT: state_next = ncpe_pkg::ST_WACC;
            ncpe_pkg::ST_WACC: begin
                state_next = i_last ? ncpe_pkg::ST_NORM : ncpe_pkg::ST_WRD;
            end
            ncpe_pkg::ST_NORM: begin
                state_next = (ws_reg > 0) ? ncpe_pkg::ST_NDIV_X : ncpe_pkg::ST_DONE;
            end
            ncpe_pkg::ST_NDIV_X: state_next = ncpe_pkg::ST_NWAIT_X;
            ncpe_pkg::ST_NWAIT_X: begin
                if (div_rsp.done) begin
                    state_next = ncpe_pkg::ST_NDIV_Y;
                end
            end
            ncpe_pkg::ST_NDIV_Y: state_next = ncpe_pkg::ST_NWAIT_Y;
            ncpe_pkg::ST_NWAIT_Y: begin
                if (div_rsp.done) begin
                    state_next = ncpe_pkg::ST_DONE;
                end
            end
            ncpe_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ncpe_pkg::ST_IDLE;
                end
            end
            default: state_next = ncpe_pkg::ST_IDLE;
        endcase
        knot_raddr = ka[KA-1:0];
    end

    assign s_ready = state_reg == ncpe_pkg::ST_IDLE;

    // Table writes happen only in idle, so no read can overlap a write
    always_ff @(posedge aclk) begin
        if (acc_in && s_data.func == ncpe_pkg::FUNC_WR_KNOT && slot_w < IW'(KNOT_DEPTH)) begin
            knot_mem[slot_w[KA-1:0]] <= s_data.knot_value;
        end
        knot_rdata <= knot_mem[knot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_in && s_data.func == ncpe_pkg::FUNC_WR_POINT && slot_w < IW'(MAX_POINTS)) begin
            pt_mem[slot_w[PA-1:0]] <= '{x: s_data.point_x, y: s_data.point_y,
                                        w: s_data.point_weight};
        end
        pt_rdata <= pt_mem[pt_raddr];
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg <= ncpe_pkg::DEGREE_RESET;
            cnt_reg <= ncpe_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ncpe_pkg::CFG_IDX_DEGREE: deg_reg <= cfg_wdata[1:0];
                ncpe_pkg::CFG_IDX_COUNT:  cnt_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier of the recurrence, and the weight and coordinate products
    logic signed [DF_W-1:0] mul_diff;
    logic signed [NB_W-1:0] mul_nb;
    logic signed [59:0]     mul_ab;
    logic signed [NW-1:0]   saved_new;
    logic signed [51:0]     mul_w;
    logic signed [63:0]     mul_x, mul_y;
    logic signed [DN_W-1:0] den_sum;

    assign mul_diff  = (state_reg == ncpe_pkg::ST_BMUL_A) ? right_reg[r1_idx] : left_reg[jr_idx];
    assign mul_nb    = nb_reg[r_reg];
    assign mul_ab    = mul_diff * mul_nb;
    assign den_sum   = DN_W'(right_reg[r1_idx]) + DN_W'(left_reg[jr_idx]);
    assign saved_new = (state_reg == ncpe_pkg::ST_BWAIT_B) ? div_rsp.quotient : '0;
    assign mul_w     = nb_reg[i_reg] * $signed({1'b0, pt_rdata.w});
    assign mul_x     = x_reg * wn_reg;
    assign mul_y     = y_reg * wn_reg;

    // Divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = DVW'(den_reg);
        priority case (state_reg)
            ncpe_pkg::ST_BDIV_A: div_req.start = !den_zero;
            ncpe_pkg::ST_BDIV_B: div_req.start = 1'b1;
            ncpe_pkg::ST_NDIV_X: begin
                div_req.start    = 1'b1;
                div_req.dividend = sx_reg;
                div_req.divisor  = DVW'(ws_reg);
            end
            ncpe_pkg::ST_NDIV_Y: begin
                div_req.start    = 1'b1;
                div_req.dividend = sy_reg;
                div_req.divisor  = DVW'(ws_reg);
            end
            default: ;
        endcase
    end

    ncpe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Knot capture control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kcap_vld_reg <= 1'b0;
        end else begin
            kcap_vld_reg <= state_reg == ncpe_pkg::ST_KLD;
        end
    end

    // Evaluation datapath
    always_ff @(posedge aclk) begin
        ktag_reg <= ld_reg;
        ld_reg   <= (state_reg == ncpe_pkg::ST_KLD) ? ld_reg + LDW'(1) : '0;

        // knot differences, one per cycle after the read
        if (kcap_vld_reg) begin
            if (ktag_reg[0]) begin
                right_reg[DGW'(ktag_reg >> 1) + DGW'(1)] <=
                    $signed({1'b0, knot_rdata}) - $signed({1'b0, u_reg});
            end else begin
                left_reg[DGW'(ktag_reg >> 1) + DGW'(1)] <=
                    $signed({1'b0, u_reg}) - $signed({1'b0, knot_rdata});
            end
        end

        unique case (state_reg)
            ncpe_pkg::ST_IDLE: begin
                u_reg <= s_data.param_t;
                p_reg <= p_eff;
                n_reg <= cnt_eff - IW'(1);
                for (int k = 0; k <= MAX_DEGREE; k++) begin
                    nb_reg[k]    <= (k == 0) ? ncpe_pkg::BASIS_ONE : '0;
                    left_reg[k]  <= '0;
                    right_reg[k] <= '0;
                end
                j_reg     <= DGW'(1);
                r_reg     <= '0;
                i_reg     <= '0;
                saved_reg <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
                ws_reg    <= '0;
                res_x_reg  <= '0;
                res_y_reg  <= '0;
                res_st_reg <= ncpe_pkg::STAT_FEW;
            end
            ncpe_pkg::ST_HI_CMP: begin
                if (hi_hit) begin
                    span_reg <= n_reg;
                end
            end
            ncpe_pkg::ST_LO_CMP: begin
                scan_k_reg <= IW'(p_reg) + IW'(2);
                if (lo_hit) begin
                    span_reg <= IW'(p_reg);
                end else begin
                    span_reg <= n_reg;
                end
            end
            ncpe_pkg::ST_SCAN: begin
                scan_k_reg <= scan_k_reg + IW'(1);
                if (scan_hit) begin
                    span_reg <= rk - IW'(1);
                end else begin
                    span_reg <= n_reg;
                end
            end
            ncpe_pkg::ST_BMUL_A: begin
                den_reg  <= den_sum;
                prod_reg <= NW'(mul_ab);
            end
            ncpe_pkg::ST_BDIV_A, ncpe_pkg::ST_BWAIT_B: begin
                if (state_reg == ncpe_pkg::ST_BDIV_A ? den_zero : div_rsp.done) begin
                    nb_reg[r_reg] <= ncpe_pkg::clamp_basis(
                        (state_reg == ncpe_pkg::ST_BWAIT_B) ? saved_reg + a_reg : saved_reg);
                    if (!r_last) begin
                        r_reg     <= r1_idx;
                        saved_reg <= saved_new;
                    end else begin
                        nb_reg[j_reg] <= ncpe_pkg::clamp_basis(saved_new);
                        j_reg     <= j_reg + DGW'(1);
                        r_reg     <= '0;
                        saved_reg <= '0;
                    end
                end
            end
            ncpe_pkg::ST_BWAIT_A: begin
                if (div_rsp.done) begin
                    a_reg    <= div_rsp.quotient;
                    prod_reg <= NW'(mul_ab);
                end
            end
            ncpe_pkg::ST_WMUL: begin
                prodw_reg <= mul_w;
                x_reg     <= pt_rdata.x;
                y_reg     <= pt_rdata.y;
            end
            ncpe_pkg::ST_WSHIFT: begin
                wn_reg <= WN_W'(ncpe_pkg::shr20_trunc(64'(prodw_reg)));
            end
            ncpe_pkg::ST_WACC: begin
                sx_reg <= sx_reg + mul_x;
                sy_reg <= sy_reg + mul_y;
                ws_reg <= ws_reg + wn_reg;
                i_reg  <= i_reg + DGW'(1);
            end
            ncpe_pkg::ST_NORM: begin
                // weight sum not positive: leave the sum unnormalized
                res_x_reg  <= ncpe_pkg::sat32(ncpe_pkg::shr20_trunc(sx_reg));
                res_y_reg  <= ncpe_pkg::sat32(ncpe_pkg::shr20_trunc(sy_reg));
                res_st_reg <= ncpe_pkg::STAT_UNNORM;
            end
            ncpe_pkg::ST_NWAIT_X: begin
                if (div_rsp.done) begin
                    res_x_reg <= ncpe_pkg::sat32(div_rsp.quotient);
                end
            end
            ncpe_pkg::ST_NWAIT_Y: begin
                if (div_rsp.done) begin
                    res_y_reg  <= ncpe_pkg::sat32(div_rsp.quotient);
                    res_st_reg <= ncpe_pkg::STAT_OK;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ncpe_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ncpe_pkg::ST_DONE && out_free) begin
            m_data_reg <= '{curve_x: res_x_reg, curve_y: res_y_reg, eval_status: res_st_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Divider is only started when free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // A result only appears out of the done state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ncpe_pkg::ST_DONE))
        else $error("result raised outside done state");

    // Chosen span lies within degree..count-1
    a_span_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ncpe_pkg::ST_KWAIT) |-> (span_reg >= IW'(p_reg) && span_reg <= n_reg))
        else $error("knot span out of range");

    // A normalized result needs a positive weight sum
    a_ok_ws: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ncpe_pkg::ST_DONE && res_st_reg == ncpe_pkg::STAT_OK) |-> (ws_reg > 0))
        else $error("ok status with non-positive weight sum");

endmodule

// ===== rtl/ncpe_div.sv =====
// Shared signed divider, truncating toward zero, two quotient bits per cycle.
module ncpe_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ncpe_pkg::ncpe_div_req_t req,
    output ncpe_pkg::ncpe_div_rsp_t rsp
);

    localparam int NW   = ncpe_pkg::DIV_NUM_W;
    localparam int DW   = ncpe_pkg::DIV_DEN_W;
    localparam int ITER = NW / ncpe_pkg::DIV_STEPS;
    localparam int CW   = $clog2(ITER);

    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;

    logic [NW-1:0] q_next;
    logic [DW-1:0] rem_next;

    // Restoring steps of one cycle
    always_comb begin
        logic [DW:0] rem_sh;
        logic        ge;
        q_next   = q_reg;
        rem_next = rem_reg;
        for (int s = 0; s < ncpe_pkg::DIV_STEPS; s++) begin
            rem_sh = {rem_next, q_next[NW-1]};
            ge     = rem_sh >= {1'b0, d_reg};
            rem_next = ge ? DW'(rem_sh - {1'b0, d_reg}) : rem_sh[DW-1:0];
            q_next   = {q_next[NW-2:0], ge};
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands in sign-magnitude form
    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg   <= req.dividend[NW-1] ? NW'(-req.dividend) : NW'(req.dividend);
            d_reg   <= req.divisor[DW-1] ? DW'(-req.divisor) : DW'(req.divisor);
            rem_reg <= '0;
            neg_reg <= req.dividend[NW-1] ^ req.divisor[DW-1];
        end else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== tb/ncpe_checker.sv =====
// Channel monitor, curve point predictor and result scoreboard for the NURBS evaluator.
module ncpe_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ncpe_pkg::ncpe_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ncpe_pkg::ncpe_out_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [ncpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ncpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending_points,
    output int                              checked_points
);
    timeunit 1ns;
    timeprecision 1ps;
    import ncpe_pkg::*;

    localparam int NPTS  = MAX_POINTS_DEF;
    localparam int NKNOT = MAX_POINTS_DEF + MAX_DEGREE_DEF + 1;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam longint Q24_LIM = 64'sd33554432;
    localparam longint Q20_DIVISOR = 64'sd1048576;

    // Shadow copy of the tables and registers
    logic signed [31:0] px_tab [NPTS];
    logic signed [31:0] py_tab [NPTS];
    logic [23:0]        pw_tab [NPTS];
    logic [31:0]        knot_tab [NKNOT];
    logic [1:0]         degree_reg;
    logic [6:0]         count_reg;

    ncpe_out_t expected_points[$];
    int fails, checked;

    function automatic longint knot_of(int k);
        longint v;
        v = 0;
        if (k < NKNOT) v = longint'({32'd0, knot_tab[k]});
        return v;
    endfunction

    function automatic longint limit_basis(longint v);
        longint r;
        r = v;
        if (v > Q24_LIM) r = Q24_LIM;
        if (v < -Q24_LIM) r = -Q24_LIM;
        return r;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Rational B-spline point at parameter t
    function automatic ncpe_out_t curve_point(logic [31:0] t);
        ncpe_out_t res;
        int deg, cnt, n, span, idx;
        longint u, nb[4], lft[4], rgt[4], saved, den, a, b, wn, sx, sy, ws;
        deg = (degree_reg == 0) ? 1 : int'(degree_reg);
        cnt = (count_reg > NPTS) ? NPTS : int'(count_reg);
        res = '0;
        if (cnt < deg + 1) begin
            res.eval_status = STAT_FEW;
            return res;
        end
        n = cnt - 1;
        u = longint'({32'd0, t});
        // Span search
        if (u >= knot_of(n + 1)) begin
            span = n;
        end else if (u <= knot_of(deg)) begin
            span = deg;
        end else begin
            span = n;
            for (int k = deg + 1; k <= n; k++) begin
                if (knot_of(k) > u) begin
                    span = k - 1;
                    break;
                end
            end
        end
        // Triangular basis recurrence
        for (int j = 0; j < 4; j++) begin
            nb[j] = 0;
            lft[j] = 0;
            rgt[j] = 0;
        end
        nb[0] = Q24_ONE;
        for (int j = 1; j <= deg; j++) begin
            saved = 0;
            lft[j] = u - knot_of(span + 1 - j);
            rgt[j] = knot_of(span + j) - u;
            for (int r = 0; r < j; r++) begin
                den = rgt[r+1] + lft[j-r];
                a = 0;
                b = 0;
                if (den != 0) begin
                    a = (rgt[r+1] * nb[r]) / den;
                    b = (lft[j-r] * nb[r]) / den;
                end
                nb[r] = limit_basis(saved + a);
                saved = b;
            end
            nb[j] = limit_basis(saved);
        end
        // Weighted sum and normalization
        sx = 0;
        sy = 0;
        ws = 0;
        for (int i = 0; i <= deg; i++) begin
            idx = span - deg + i;
            if (idx < NPTS) begin
                wn = (nb[i] * longint'({40'd0, pw_tab[idx]})) / Q20_DIVISOR;
                sx += longint'(px_tab[idx]) * wn;
                sy += longint'(py_tab[idx]) * wn;
                ws += wn;
            end
        end
        if (ws > 0) begin
            res.curve_x = clip32(sx / ws);
            res.curve_y = clip32(sy / ws);
            res.eval_status = STAT_OK;
        end else begin
            res.curve_x = clip32(sx / Q20_DIVISOR);
            res.curve_y = clip32(sy / Q20_DIVISOR);
            res.eval_status = STAT_UNNORM;
        end
        return res;
    endfunction

    // Monitor: register writes, input transactions, result transactions
    always @(posedge aclk) begin
        ncpe_out_t want;
        if (!aresetn) begin
            degree_reg = DEGREE_RESET;
            count_reg = COUNT_RESET;
            expected_points.delete();
            fails = 0;
            checked = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_IDX_DEGREE) degree_reg = cfg_wdata[1:0];
                else if (cfg_index == CFG_IDX_COUNT) count_reg = cfg_wdata[6:0];
            end
            if (s_valid && s_ready) begin
                case (s_data.func)
                    FUNC_WR_POINT: begin
                        if (s_data.slot < NPTS) begin
                            px_tab[s_data.slot] = s_data.point_x;
                            py_tab[s_data.slot] = s_data.point_y;
                            pw_tab[s_data.slot] = s_data.point_weight;
                        end
                    end
                    FUNC_WR_KNOT: begin
                        if (s_data.slot < NKNOT) knot_tab[s_data.slot] = s_data.knot_value;
                    end
                    FUNC_EVAL: expected_points.push_back(curve_point(s_data.param_t));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    fails++;
                    $display("%t: result transaction with none expected: x=%0d y=%0d st=%0d",
                             $realtime, m_data.curve_x, m_data.curve_y, m_data.eval_status);
                end else begin
                    want = expected_points.pop_front();
                    checked++;
                    if (m_data !== want) begin
                        fails++;
                        $display("%t: mismatch exp x=%0d y=%0d st=%0d act x=%0d y=%0d st=%0d",
                                 $realtime, want.curve_x, want.curve_y, want.eval_status,
                                 m_data.curve_x, m_data.curve_y, m_data.eval_status);
                    end
                end
            end
        end
        fail_count <= fails;
        pending_points <= expected_points.size();
        checked_points <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, clock, reset and verdict for the NURBS curve point evaluator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ncpe_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int NUM_ITEMS   = 1950;
    localparam int QUIET_ITEMS = 200;
    localparam int SETTLE      = 40;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ncpe_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ncpe_out_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_DEGREE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count, pending_points, checked_points;
    int sent, phases, cycles;
    bit stalls_on = 1'b1;
    logic [31:0] t_lo, t_hi;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nurbs_curve_point_eval_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    ncpe_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_points(pending_points),
        .checked_points(checked_points)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side back-pressure
    initial begin
        @(posedge aclk);
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // One input transaction, with an optional idle burst ahead of it
    task automatic push(input logic [1:0] f, input int unsigned sl, input logic [31:0] x,
                        input logic [31:0] y, input logic [23:0] w, input logic [31:0] k,
                        input logic [31:0] t);
        ncpe_in_t it;
        it.func = f;
        it.slot = sl[6:0];
        it.point_x = x;
        it.point_y = y;
        it.point_weight = w;
        it.knot_value = k;
        it.param_t = t;
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic eval_at(input logic [31:0] t);
        push(FUNC_EVAL, $urandom_range(0, 127), $urandom, $urandom, $urandom, $urandom, t);
    endtask

    // Drain every expected result, let the block settle, then write both registers
    task automatic set_config(input logic [1:0] deg, input logic [6:0] cnt);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_DEGREE;
        cfg_wdata <= {5'd0, deg};
        @(posedge aclk);
        cfg_index <= CFG_IDX_COUNT;
        cfg_wdata <= cnt;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        phases++;
    endtask

    // Clamped, non-decreasing knot vector plus random control points
    task automatic build_curve(input int deg, input int cnt, input bit wide);
        logic [31:0] kv;
        int last;
        kv = wide ? $urandom : $urandom_range(0, 32'h0010_0000);
        last = cnt + deg;
        if (last > 67) last = 67;
        t_lo = kv;
        for (int i = 0; i <= last; i++) begin
            if (i > deg && i <= cnt && $urandom_range(0, 4) != 0)
                kv = (kv > 32'hFFF0_0000) ? kv : kv + $urandom_range(1, 32'h0004_0000);
            if (i == cnt) t_hi = kv;
            push(FUNC_WR_KNOT, i, $urandom, $urandom, $urandom, kv, $urandom);
        end
        if (cnt > last) t_hi = kv;
        for (int i = 0; i < cnt && i < 64; i++) begin
            push(FUNC_WR_POINT, i,
                 wide ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                 wide ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                 $urandom_range(0, 3) == 0 ? 24'h01_0000 : 24'($urandom_range(1, 24'hFF_FFFF)),
                 $urandom, $urandom);
        end
    endtask

    initial begin
        int deg, cnt, burst;
        logic [31:0] t;
        cycles = 0;
        sent = 0;
        phases = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every table entry so nothing unwritten is ever read
        for (int i = 0; i < 68; i++) begin
            if (i < 64) push(FUNC_WR_POINT, i, $urandom, $urandom, 24'h01_0000, 0, 0);
            push(FUNC_WR_KNOT, i, 0, 0, 0, i * 32'h0001_0000, 0);
        end

        // Directed: too few points at reset count, extremes, odd codes
        eval_at(32'h0);
        set_config(2'd0, 7'd127);
        eval_at(32'hFFFF_FFFF);
        eval_at(32'h0);
        eval_at(32'h0002_8000);
        push(FUNC_WR_POINT, 64, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 0, 0);
        push(FUNC_WR_POINT, 127, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 0, 0);
        push(FUNC_WR_KNOT, 68, 0, 0, 0, 32'hFFFF_FFFF, 0);
        push(FUNC_WR_KNOT, 127, 0, 0, 0, 32'hFFFF_FFFF, 0);
        push(2'd3, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 0);
        push(FUNC_WR_POINT, 2, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 0, 0);
        push(FUNC_WR_POINT, 3, 32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0001, 0, 0);
        set_config(2'd3, 7'd64);
        eval_at(32'h0003_0000);
        eval_at(32'h0042_0000);
        eval_at(32'h0020_8000);
        // Repeated knots give zero denominators
        push(FUNC_WR_KNOT, 30, 0, 0, 0, 32'h001F_0000, 0);
        push(FUNC_WR_KNOT, 31, 0, 0, 0, 32'h001F_0000, 0);
        eval_at(32'h001F_0000);
        set_config(2'd3, 7'd3);
        eval_at(32'h0001_0000);
        set_config(2'd1, 7'd2);
        eval_at(32'h0001_8000);

        // Random phases
        while (sent < NUM_ITEMS) begin
            if (sent > NUM_ITEMS - QUIET_ITEMS) stalls_on = 1'b0;
            deg = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0: cnt = $urandom_range(0, 4);
                1: cnt = 64;
                2: cnt = $urandom_range(65, 127);
                default: cnt = $urandom_range(4, 16);
            endcase
            set_config(deg, cnt);
            if ($urandom_range(0, 3) != 0)
                build_curve(deg == 0 ? 1 : deg, cnt > 64 ? 64 : cnt, $urandom_range(0, 5) == 0);
            burst = $urandom_range(5, 40);
            for (int i = 0; i < burst; i++) begin
                case ($urandom_range(0, 15))
                    0: push(FUNC_WR_POINT, $urandom_range(0, 127), $urandom, $urandom,
                            24'($urandom_range(1, 24'hFF_FFFF)), $urandom, $urandom);
                    1: push(FUNC_WR_KNOT, $urandom_range(0, 127), $urandom, $urandom,
                            $urandom, $urandom, $urandom);
                    2: push(2'd3, $urandom_range(0, 127), $urandom, $urandom, $urandom,
                            $urandom, $urandom);
                    3: eval_at($urandom);
                    4: eval_at($urandom_range(0, 1) ? t_lo : t_hi);
                    default: begin
                        t = (t_hi > t_lo) ? $urandom_range(t_lo, t_hi) : t_lo;
                        eval_at(t);
                    end
                endcase
            end
        end

        // Wind down
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_points != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("tb_top: %0d input transactions over %0d register settings, %0d points checked",
                 sent, phases, checked_points);
        $display("tb_top: degrees 0..3, counts 0..127, clamped and random knots, odd codes");
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
